// ----- rtl/handheld_timer_divider_top_defines.svh -----
// Assertion macros used by the checker file of the divider and timer block.
`ifndef HANDHELD_TIMER_DIVIDER_TOP_DEFINES_SVH
`define HANDHELD_TIMER_DIVIDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htd assertion failed");

`endif

// ----- rtl/htd_pkg.sv -----
// Package with the codes, constants and tap selection of the divider and timer block.
package htd_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_TIMA = 2'd1;
    localparam logic [1:0] REG_TMA  = 2'd2;
    localparam logic [1:0] REG_TAC  = 2'd3;

    localparam logic [2:0] TAC_ENABLE_MASK = 3'h4;
    localparam logic [2:0] TAC_SELECT_MASK = 3'h3;
    localparam logic [7:0] TAC_CTRL_MASK   = 8'h07;
    localparam logic [7:0] TAC_READ_FILL   = 8'hF8;
    localparam logic [2:0] RELOAD_TICKS    = 3'd4;

    // Divider bit watched for each clock select code.
    localparam logic [3:0] TAP_POS [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

    // Timer signal: the selected divider bit gated by the enable bit.
    function automatic logic timer_level(input logic [2:0] ctrl, input logic [15:0] div);
        logic [1:0] sel;
        sel = ctrl[1:0] & TAC_SELECT_MASK[1:0];
        return ((ctrl & TAC_ENABLE_MASK) != 3'd0) && div[TAP_POS[sel]];
    endfunction

endpackage

// ----- rtl/handheld_timer_divider_top.sv -----
// Top level of the divider and timer block: input stage, state update and result register.
//
// While o_ready is high, the block takes one item per cycle on the input channel
// (i_valid, o_ready) carrying an action (tick, register write or register read), a
// register select and a write byte. Every item yields exactly one result item on the
// output channel (o_valid, i_ready) carrying the read byte and the timer interrupt flag.
// An accepted item waits in the input register; once the result register is empty or
// being drained, it updates the divider, counter, modulo, control and reload state, and
// its result is loaded into the result register at the same edge. The whole state
// update is one short pass of logic, and the following item sees the state left by the
// previous one. When the receiver stalls, the result register holds its item and the
// input register still takes one more item; only when both are full does o_ready drop.
// Synchronous reset clears the timer state to zero and empties both stages.
module handheld_timer_divider_top
    import htd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [1:0] i_reg_sel,
    input  logic [7:0] i_write_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_timer_irq
);

    // Input stage.
    logic       r_in_valid;
    logic [1:0] r_in_action;
    logic [1:0] r_in_sel;
    logic [7:0] r_in_value;

    // Result stage.
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_irq;

    // Architectural state.
    logic [15:0] r_divider,   n_divider;
    logic [7:0]  r_counter,   n_counter;
    logic [7:0]  r_modulo,    n_modulo;
    logic [2:0]  r_control,   n_control;
    logic        r_last,      n_last;
    logic        r_pending,   n_pending;
    logic [2:0]  r_countdown, n_countdown;

    logic [7:0] n_data;
    logic       n_irq;
    logic       do_sample;
    logic       level;
    logic       advance;

    // The input item moves on when the result register is empty or being drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        n_divider   = r_divider;
        n_counter   = r_counter;
        n_modulo    = r_modulo;
        n_control   = r_control;
        n_last      = r_last;
        n_pending   = r_pending;
        n_countdown = r_countdown;
        n_data      = 8'd0;
        n_irq       = 1'b0;
        do_sample   = 1'b0;
        level       = 1'b0;

        if (advance) begin
            unique case (r_in_action)
                ACT_TICK: begin
                    // A queued reload counts down on ticks only and lands at zero.
                    if (r_pending) begin
                        n_countdown = r_countdown - 3'd1;
                        if (n_countdown == 3'd0) begin
                            n_counter = r_modulo;
                            n_irq     = 1'b1;
                            n_pending = 1'b0;
                        end
                    end
                    n_divider = r_divider + 16'd1;
                    do_sample = 1'b1;
                end
                ACT_WRITE: begin
                    unique case (r_in_sel)
                        REG_DIV: begin
                            n_divider = 16'd0;
                            do_sample = 1'b1;
                        end
                        REG_TIMA: begin
                            // Writing the counter during the delay cancels the reload.
                            if (r_countdown != 3'd0) begin
                                n_pending   = 1'b0;
                                n_countdown = 3'd0;
                            end
                            n_counter = r_in_value;
                        end
                        REG_TMA: begin
                            n_modulo = r_in_value;
                            if (r_countdown != 3'd0 && r_counter == 8'd0) begin
                                n_counter = r_in_value;
                            end
                        end
                        REG_TAC: begin
                            n_control = r_in_value[2:0] & TAC_CTRL_MASK[2:0];
                            do_sample = 1'b1;
                        end
                    endcase
                end
                ACT_READ: begin
                    unique case (r_in_sel)
                        REG_DIV:  n_data = r_divider[15:8];
                        REG_TIMA: n_data = r_counter;
                        REG_TMA:  n_data = r_modulo;
                        REG_TAC:  n_data = TAC_READ_FILL | {5'd0, r_control};
                    endcase
                end
                default: begin
                    // The unused action code leaves the state alone.
                end
            endcase

            // A falling edge of the timer signal bumps the counter; a wrap queues a reload.
            if (do_sample) begin
                level = timer_level(n_control, n_divider);
                if (n_last && !level) begin
                    n_counter = n_counter + 8'd1;
                    if (n_counter == 8'd0) begin
                        n_pending   = 1'b1;
                        n_countdown = RELOAD_TICKS;
                    end
                end
                n_last = level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_divider   <= 16'd0;
            r_counter   <= 8'd0;
            r_modulo    <= 8'd0;
            r_control   <= 3'd0;
            r_last      <= 1'b0;
            r_pending   <= 1'b0;
            r_countdown <= 3'd0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_divider   <= n_divider;
            r_counter   <= n_counter;
            r_modulo    <= n_modulo;
            r_control   <= n_control;
            r_last      <= n_last;
            r_pending   <= n_pending;
            r_countdown <= n_countdown;
        end
    end

    // Payload registers load on their stage's handshake and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_action <= i_action;
            r_in_sel    <= i_reg_sel;
            r_in_value  <= i_write_value;
        end
        if (advance) begin
            r_out_data <= n_data;
            r_out_irq  <= n_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_timer_irq = r_out_irq;

endmodule

// ----- rtl/htd_checker.sv -----
// Port checker for the divider and timer block and its bind to the top level.
`include "handheld_timer_divider_top_defines.svh"

module htd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_timer_irq
);

    // A stalled result keeps its value.
    `HTD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_read_data) && $stable(o_timer_irq))

    // The input side stalls only when a result is waiting at the output.
    `HTD_ASSERT_NOW(a_stall_needs_result, i_clk, i_rst_n, !o_ready, o_valid)

    // An interrupt comes only from a tick, which never carries read data.
    `HTD_ASSERT_NOW(a_irq_no_data, i_clk, i_rst_n, o_valid && o_timer_irq,
        o_read_data == 8'd0)

    // After a reload lands, the next result item cannot be another reload.
    `HTD_ASSERT_NEXT(a_irq_spacing, i_clk, i_rst_n, o_valid && o_timer_irq && i_ready,
        !(o_valid && o_timer_irq))

endmodule

bind handheld_timer_divider_top htd_checker u_htd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_read_data (o_read_data),
    .o_timer_irq (o_timer_irq)
);

// ----- test/tb.sv -----
// Self-checking testbench for the divider and timer block with a shadow timer and random stalls.
module tb;
    import htd_pkg::*;

    // Action code 3 does nothing in the block, so the package gives it no name.
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam logic [7:0] CTRL_READ_FILL = 8'hF8;
    localparam logic [2:0] RELOAD_DELAY   = 3'd4;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         RANDOM_TARGET  = 1100;
    localparam int         HOLD_SPACING   = 350;

    // One bus operation as it goes to the block, plus a flag that makes the driver hold it
    // back until every earlier operation has produced its result.
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] sel;
        logic [7:0] value;
        logic       hold;
    } bus_op_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
    } timer_out_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [1:0] i_action      = ACT_TICK;
    logic [1:0] i_reg_sel     = REG_DIV;
    logic [7:0] i_write_value = 8'h00;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic       o_timer_irq;

    handheld_timer_divider_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_reg_sel     (i_reg_sel),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_timer_irq   (o_timer_irq)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Operations waiting to be driven, and results the shadow timer says are still due.
    bus_op_t    bus_ops[$];
    timer_out_t due_timer_results[$];

    // Both counters change only through nonblocking assignments, so every block that
    // reads them at a clock edge sees the values from before that edge.
    int ops_accepted = 0;
    int results_seen = 0;
    int cycle_count  = 0;
    int error_count  = 0;
    bit hold_next    = 1'b0;

    // Shadow copy of the timer state, all zero after reset.
    logic [15:0] shadow_div    = '0;
    logic [7:0]  shadow_tima   = '0;
    logic [7:0]  shadow_tma    = '0;
    logic [2:0]  shadow_tac    = '0;
    logic        shadow_level  = 1'b0;
    logic        shadow_reload = 1'b0;
    logic [2:0]  shadow_count  = '0;

    // A long stretch of the random part runs with neither side idling.
    wire calm = (ops_accepted >= 400) && (ops_accepted < 700);

    // Re-evaluates the gated timer signal; a high-to-low change bumps the counter, and a
    // wrap to zero queues the delayed reload (restarting the countdown if one is queued).
    function automatic void sample_timer_level();
        logic level;
        logic tap;
        case (shadow_tac[1:0])
            2'd0:    tap = shadow_div[9];
            2'd1:    tap = shadow_div[3];
            2'd2:    tap = shadow_div[5];
            default: tap = shadow_div[7];
        endcase
        level = shadow_tac[2] && tap;
        if (shadow_level && !level) begin
            shadow_tima = shadow_tima + 8'd1;
            if (shadow_tima == 8'd0) begin
                shadow_reload = 1'b1;
                shadow_count  = RELOAD_DELAY;
            end
        end
        shadow_level = level;
    endfunction

    // Applies one accepted operation to the shadow timer and returns its result.
    function automatic timer_out_t predict_timer_op(input bus_op_t op);
        timer_out_t res;
        res = '0;
        case (op.action)
            ACT_TICK: begin
                if (shadow_reload) begin
                    shadow_count = shadow_count - 3'd1;
                    if (shadow_count == 3'd0) begin
                        shadow_tima   = shadow_tma;
                        res.irq       = 1'b1;
                        shadow_reload = 1'b0;
                    end
                end
                shadow_div = shadow_div + 16'd1;
                sample_timer_level();
            end
            ACT_WRITE: begin
                case (op.sel)
                    REG_DIV: begin
                        shadow_div = '0;
                        sample_timer_level();
                    end
                    REG_TIMA: begin
                        // A counter write inside the reload delay cancels the reload.
                        if (shadow_count != 3'd0) begin
                            shadow_reload = 1'b0;
                            shadow_count  = 3'd0;
                        end
                        shadow_tima = op.value;
                    end
                    REG_TMA: begin
                        shadow_tma = op.value;
                        if (shadow_count != 3'd0 && shadow_tima == 8'd0) begin
                            shadow_tima = op.value;
                        end
                    end
                    REG_TAC: begin
                        shadow_tac = op.value[2:0];
                        sample_timer_level();
                    end
                endcase
            end
            ACT_READ: begin
                case (op.sel)
                    REG_DIV:  res.rdata = shadow_div[15:8];
                    REG_TIMA: res.rdata = shadow_tima;
                    REG_TMA:  res.rdata = shadow_tma;
                    REG_TAC:  res.rdata = CTRL_READ_FILL | {5'd0, shadow_tac};
                endcase
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic push_op(input logic [1:0] action, input logic [1:0] sel,
                           input logic [7:0] value);
        bus_op_t op;
        op.action = action;
        op.sel    = sel;
        op.value  = value;
        op.hold   = hold_next;
        hold_next = 1'b0;
        bus_ops.push_back(op);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        if (error_count < 20) begin
            $display("mismatch at result %0d: %s expected %h got %h",
                     results_seen, what, want, got);
        end
        error_count = error_count + 1;
    endtask

    // Driver: presents the head of bus_ops, keeps it steady until accepted, and feeds the
    // shadow timer with every operation at the edge where it is accepted.
    always @(posedge i_clk) begin
        bus_op_t sent;
        bit      took_op;
        bit      took_result;
        bit      settled;
        bit      rest;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took_op     = i_valid && o_ready;
            took_result = o_valid && i_ready;
            if (took_op) begin
                sent.action = i_action;
                sent.sel    = i_reg_sel;
                sent.value  = i_write_value;
                sent.hold   = 1'b0;
                due_timer_results.push_back(predict_timer_op(sent));
                void'(bus_ops.pop_front());
                ops_accepted <= ops_accepted + 1;
            end
            if (!i_valid || took_op) begin
                settled = (ops_accepted + int'(took_op)) == (results_seen + int'(took_result));
                rest    = !calm && ($urandom_range(0, 99) < 16);
                // A held operation waits until the block has returned everything.
                if (bus_ops.size() != 0 && bus_ops[0].hold && !settled) begin
                    rest = 1'b1;
                end
                if (bus_ops.size() == 0 || rest) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid       <= 1'b1;
                    i_action      <= bus_ops[0].action;
                    i_reg_sel     <= bus_ops[0].sel;
                    i_write_value <= bus_ops[0].value;
                end
            end
        end
    end

    // Monitor: stalls the result channel at random and checks every accepted result
    // against the oldest one the shadow timer predicted.
    always @(posedge i_clk) begin
        timer_out_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (due_timer_results.size() == 0) begin
                    report_mismatch("result with nothing due", 8'h00, o_read_data);
                end else begin
                    want = due_timer_results.pop_front();
                    if (o_read_data !== want.rdata) begin
                        report_mismatch("read_data", want.rdata, o_read_data);
                    end
                    if (o_timer_irq !== want.irq) begin
                        report_mismatch("timer_irq", {7'd0, want.irq}, {7'd0, o_timer_irq});
                    end
                end
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int          runs;
        int          roll;
        int          pick;
        logic [1:0]  tap_sel;
        int          next_hold;

        // Directed part. Reset values first, then the unused action code.
        push_op(ACT_READ, REG_DIV, 8'h00);
        push_op(ACT_READ, REG_TAC, 8'hFF);
        push_op(ACT_UNUSED, REG_TAC, 8'hFF);
        // Counter one step from wrapping, fastest tap enabled but its bit still low.
        push_op(ACT_WRITE, REG_TMA, 8'hAB);
        push_op(ACT_WRITE, REG_TIMA, 8'hFF);
        push_op(ACT_WRITE, REG_TAC, 8'h05);
        // Eight ticks raise divider bit 3, so the timer signal goes high.
        repeat (8) push_op(ACT_TICK, REG_DIV, 8'h00);
        // Disabling the timer drops the signal: the counter wraps and a reload is queued.
        push_op(ACT_WRITE, REG_TAC, 8'h00);
        // Modulo write inside the delay while the counter is zero also loads the counter.
        push_op(ACT_WRITE, REG_TMA, 8'hFF);
        // A second wrap through a control write while the reload is still queued.
        push_op(ACT_WRITE, REG_TAC, 8'h05);
        push_op(ACT_WRITE, REG_TAC, 8'h01);
        // The restarted countdown ends on the fourth tick with the interrupt.
        repeat (4) push_op(ACT_TICK, REG_DIV, 8'h00);
        // A divider write drops the high tap bit: another wrap, then a counter write
        // inside the delay cancels that reload.
        push_op(ACT_WRITE, REG_TAC, 8'h05);
        push_op(ACT_WRITE, REG_DIV, 8'hA5);
        push_op(ACT_WRITE, REG_TIMA, 8'h00);
        push_op(ACT_READ, REG_TIMA, 8'h00);
        push_op(ACT_READ, REG_TMA, 8'h00);

        // Random part: mostly timer runs with the counter set up near its wrap point,
        // with register traffic mixed in; the rest is unstructured noise.
        hold_next = 1'b1;
        next_hold = bus_ops.size() + HOLD_SPACING;
        while (bus_ops.size() < RANDOM_TARGET + 25) begin
            if (bus_ops.size() >= next_hold) begin
                hold_next = 1'b1;
                next_hold = next_hold + HOLD_SPACING;
            end
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                tap_sel = ($urandom_range(0, 1) == 0) ? 2'd1 : 2'($urandom_range(0, 3));
                push_op(ACT_WRITE, REG_TAC, {5'($urandom_range(0, 31)), 1'b1, tap_sel});
                if ($urandom_range(0, 1) == 0) begin
                    push_op(ACT_WRITE, REG_TIMA, 8'($urandom_range(8'hF0, 8'hFF)));
                end else begin
                    push_op(ACT_WRITE, REG_TIMA, 8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 2) == 0) begin
                    push_op(ACT_WRITE, REG_TMA, 8'($urandom_range(0, 255)));
                end
                runs = $urandom_range(8, 48);
                repeat (runs) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 78) begin
                        push_op(ACT_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    end else if (pick < 86) begin
                        push_op(ACT_READ, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    end else if (pick < 90) begin
                        push_op(ACT_WRITE, REG_TMA, 8'($urandom_range(0, 255)));
                    end else if (pick < 93) begin
                        push_op(ACT_WRITE, REG_TIMA, 8'($urandom_range(8'hF8, 8'hFF)));
                    end else if (pick < 96) begin
                        push_op(ACT_WRITE, REG_TAC, 8'($urandom_range(0, 255)));
                    end else if (pick < 98) begin
                        push_op(ACT_WRITE, REG_DIV, 8'($urandom_range(0, 255)));
                    end else begin
                        push_op(ACT_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    end
                end
            end else begin
                runs = $urandom_range(3, 12);
                repeat (runs) begin
                    push_op(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)));
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every operation has gone in and every result has come back.
        do @(posedge i_clk); while (bus_ops.size() != 0 || i_valid);
        while (ops_accepted != results_seen) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_timer_results.size() != 0) begin
            report_mismatch("results never delivered", 8'h00, 8'(due_timer_results.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/htd_pkg.sv
rtl/handheld_timer_divider_top.sv
rtl/htd_checker.sv
test/tb.sv
